// File: rtl/cvc_pkg.sv
package cvc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_SMALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_BIG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TEMP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BREW_TEMP    = 3'd6;

  // register reset values
  localparam logic [9:0] RST_PRICE_SMALL  = 10'd50;
  localparam logic [9:0] RST_PRICE_MEDIUM = 10'd100;
  localparam logic [9:0] RST_PRICE_BIG    = 10'd150;
  localparam logic [7:0] RST_TIMEOUT      = 8'd120;
  localparam logic [7:0] RST_TEMP_PERIOD  = 8'd5;
  localparam logic [6:0] RST_HOLD_TEMP    = 7'd70;
  localparam logic [6:0] RST_BREW_TEMP    = 7'd75;

  // commands
  localparam logic [2:0] CMD_SIZE   = 3'd0;
  localparam logic [2:0] CMD_COIN   = 3'd1;
  localparam logic [2:0] CMD_CANCEL = 3'd2;
  localparam logic [2:0] CMD_OFF    = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // size codes
  localparam logic [1:0] SIZE_SMALL  = 2'd0;
  localparam logic [1:0] SIZE_MEDIUM = 2'd1;
  localparam logic [1:0] SIZE_BIG    = 2'd2;

  // accepted coins
  localparam logic [7:0] COIN_10  = 8'd10;
  localparam logic [7:0] COIN_20  = 8'd20;
  localparam logic [7:0] COIN_50  = 8'd50;
  localparam logic [7:0] COIN_100 = 8'd100;

  localparam logic [6:0] TEMP_MAX = 7'd127;
  localparam logic [6:0] TEMP_MIN = 7'd0;

  // event codes
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_BAD_SIZE  = 4'd1;
  localparam logic [3:0] EV_SIZE_OK   = 4'd2;
  localparam logic [3:0] EV_SHORT     = 4'd3;
  localparam logic [3:0] EV_BAD_COIN  = 4'd4;
  localparam logic [3:0] EV_CANCEL    = 4'd5;
  localparam logic [3:0] EV_TIMEOUT   = 4'd6;
  localparam logic [3:0] EV_DISPENSED = 4'd7;
  localparam logic [3:0] EV_OFF       = 4'd8;
  localparam logic [3:0] EV_IGNORED   = 4'd9;

  // mode codes as shown on the result word
  localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CODE_SIZE = 2'd1;
  localparam logic [1:0] MODE_CODE_BREW = 2'd2;
  localparam logic [1:0] MODE_CODE_OFF  = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_SIZE = 4'b0010,
    MODE_BREW = 4'b0100,
    MODE_OFF  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [9:0] price_small;
    logic [9:0] price_medium;
    logic [9:0] price_big;
    logic [7:0] timeout_ticks;
    logic [7:0] temp_period_ticks;
    logic [6:0] hold_temp;
    logic [6:0] brew_temp;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [10:0] coin_total;
    logic [10:0] refund;
    logic [6:0]  temperature;
    logic [1:0]  mode;
    logic [9:0]  price_due;
  } res_t;

endpackage

// File: rtl/cvc_cfg.sv
module cvc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cvc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cvc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cvc_pkg::cfg_t                  cfg
);

  cvc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.price_small       <= cvc_pkg::RST_PRICE_SMALL;
      cfg_r.price_medium      <= cvc_pkg::RST_PRICE_MEDIUM;
      cfg_r.price_big         <= cvc_pkg::RST_PRICE_BIG;
      cfg_r.timeout_ticks     <= cvc_pkg::RST_TIMEOUT;
      cfg_r.temp_period_ticks <= cvc_pkg::RST_TEMP_PERIOD;
      cfg_r.hold_temp         <= cvc_pkg::RST_HOLD_TEMP;
      cfg_r.brew_temp         <= cvc_pkg::RST_BREW_TEMP;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cvc_pkg::REG_PRICE_SMALL:  cfg_r.price_small       <= cfg_wdata;
        cvc_pkg::REG_PRICE_MEDIUM: cfg_r.price_medium      <= cfg_wdata;
        cvc_pkg::REG_PRICE_BIG:    cfg_r.price_big         <= cfg_wdata;
        cvc_pkg::REG_TIMEOUT:      cfg_r.timeout_ticks     <= cfg_wdata[7:0];
        cvc_pkg::REG_TEMP_PERIOD:  cfg_r.temp_period_ticks <= cfg_wdata[7:0];
        cvc_pkg::REG_HOLD_TEMP:    cfg_r.hold_temp         <= cfg_wdata[6:0];
        cvc_pkg::REG_BREW_TEMP:    cfg_r.brew_temp         <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/cvc_core.sv
module cvc_core #(
  parameter logic [6:0] START_TEMP = 7'd65
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [2:0]    cmd,
  input  logic [1:0]    size_code,
  input  logic [7:0]    coin_cents,
  input  cvc_pkg::cfg_t cfg,
  output cvc_pkg::res_t res
);

  cvc_pkg::mode_t mode_r, mode_nxt;
  logic [10:0]    sum_r, sum_nxt;
  logic [9:0]     price_r, price_nxt;
  logic [6:0]     temp_r, temp_nxt;
  logic [7:0]     left_r, left_nxt;
  logic           armed_r, armed_nxt;
  logic [7:0]     presc_r, presc_nxt;
  logic [3:0]     ev;
  logic [10:0]    refund;
  logic [9:0]     size_price;
  logic           coin_ok;
  logic           paid;

  function automatic logic [6:0] heat_step(input logic [6:0] t, input logic pd,
                                           input logic [6:0] brew, input logic [6:0] hold);
    logic [6:0] r;
    r = t;
    if (pd) begin
      if (t <= brew && t != cvc_pkg::TEMP_MAX) r = t + 7'd1;
    end else if (t <= hold) begin
      if (t != cvc_pkg::TEMP_MAX) r = t + 7'd1;
    end else if (t != cvc_pkg::TEMP_MIN) begin
      r = t - 7'd1;
    end
    return r;
  endfunction

  function automatic logic [1:0] mode_code(input cvc_pkg::mode_t m);
    logic [1:0] c;
    unique case (m)
      cvc_pkg::MODE_IDLE: c = cvc_pkg::MODE_CODE_IDLE;
      cvc_pkg::MODE_SIZE: c = cvc_pkg::MODE_CODE_SIZE;
      cvc_pkg::MODE_BREW: c = cvc_pkg::MODE_CODE_BREW;
      cvc_pkg::MODE_OFF:  c = cvc_pkg::MODE_CODE_OFF;
      default:            c = cvc_pkg::MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  always_comb begin
    unique case (size_code)
      cvc_pkg::SIZE_SMALL:  size_price = cfg.price_small;
      cvc_pkg::SIZE_MEDIUM: size_price = cfg.price_medium;
      cvc_pkg::SIZE_BIG:    size_price = cfg.price_big;
      default:              size_price = 10'd0;
    endcase
  end

  assign coin_ok = (coin_cents == cvc_pkg::COIN_10) || (coin_cents == cvc_pkg::COIN_20) ||
                   (coin_cents == cvc_pkg::COIN_50) || (coin_cents == cvc_pkg::COIN_100);

  // tick work runs in order: timeout, prescaler and heater, dispense check
  always_comb begin
    mode_nxt  = mode_r;
    sum_nxt   = sum_r;
    price_nxt = price_r;
    temp_nxt  = temp_r;
    left_nxt  = left_r;
    armed_nxt = armed_r;
    presc_nxt = presc_r;
    ev        = cvc_pkg::EV_NONE;
    refund    = 11'd0;
    paid      = 1'b0;

    if (cmd == cvc_pkg::CMD_TICK) begin
      if (mode_r != cvc_pkg::MODE_OFF) begin
        if (armed_r) begin
          if (left_r != 8'd0) left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) begin
            refund    = sum_r;
            ev        = cvc_pkg::EV_TIMEOUT;
            mode_nxt  = cvc_pkg::MODE_IDLE;
            sum_nxt   = 11'd0;
            price_nxt = 10'd0;
            armed_nxt = 1'b0;
            left_nxt  = 8'd0;
          end
        end
        presc_nxt = presc_r + 8'd1;
        if (presc_nxt >= cfg.temp_period_ticks) begin
          presc_nxt = 8'd0;
          paid      = (price_nxt != 10'd0) && ({1'b0, price_nxt} <= sum_nxt);
          temp_nxt  = heat_step(temp_r, paid, cfg.brew_temp, cfg.hold_temp);
        end
        if (mode_nxt == cvc_pkg::MODE_BREW && temp_nxt > cfg.brew_temp) begin
          ev        = cvc_pkg::EV_DISPENSED;
          mode_nxt  = cvc_pkg::MODE_IDLE;
          sum_nxt   = 11'd0;
          price_nxt = 10'd0;
          armed_nxt = 1'b0;
          left_nxt  = 8'd0;
        end
      end
    end else if (cmd > cvc_pkg::CMD_TICK || mode_r == cvc_pkg::MODE_OFF ||
                 mode_r == cvc_pkg::MODE_BREW) begin
      ev = cvc_pkg::EV_IGNORED;
    end else if (cmd == cvc_pkg::CMD_OFF) begin
      mode_nxt = cvc_pkg::MODE_OFF;
      ev       = cvc_pkg::EV_OFF;
    end else if (mode_r == cvc_pkg::MODE_IDLE) begin
      if (cmd == cvc_pkg::CMD_SIZE) begin
        if (size_price != 10'd0) begin
          price_nxt = size_price;
          mode_nxt  = cvc_pkg::MODE_SIZE;
          ev        = cvc_pkg::EV_SIZE_OK;
        end else begin
          ev = cvc_pkg::EV_BAD_SIZE;
        end
      end else begin
        ev = cvc_pkg::EV_IGNORED;
      end
    end else begin
      if (cmd == cvc_pkg::CMD_CANCEL) begin
        refund    = sum_r;
        ev        = cvc_pkg::EV_CANCEL;
        mode_nxt  = cvc_pkg::MODE_IDLE;
        sum_nxt   = 11'd0;
        price_nxt = 10'd0;
        armed_nxt = 1'b0;
        left_nxt  = 8'd0;
      end else if (cmd == cvc_pkg::CMD_SIZE) begin
        ev = cvc_pkg::EV_IGNORED;
      end else if (coin_ok) begin
        sum_nxt   = sum_r + {3'd0, coin_cents};
        armed_nxt = 1'b1;
        left_nxt  = cfg.timeout_ticks;
        if (sum_nxt < {1'b0, price_r}) begin
          ev = cvc_pkg::EV_SHORT;
        end else begin
          armed_nxt = 1'b0;
          left_nxt  = 8'd0;
          mode_nxt  = cvc_pkg::MODE_BREW;
          ev        = cvc_pkg::EV_NONE;
          // boiler already hot enough: dispense straight away
          if (temp_r > cfg.brew_temp) begin
            ev        = cvc_pkg::EV_DISPENSED;
            mode_nxt  = cvc_pkg::MODE_IDLE;
            sum_nxt   = 11'd0;
            price_nxt = 10'd0;
          end
        end
      end else begin
        ev = cvc_pkg::EV_BAD_COIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cvc_pkg::MODE_IDLE;
      sum_r   <= 11'd0;
      price_r <= 10'd0;
      temp_r  <= START_TEMP;
      left_r  <= 8'd0;
      armed_r <= 1'b0;
      presc_r <= 8'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      sum_r   <= sum_nxt;
      price_r <= price_nxt;
      temp_r  <= temp_nxt;
      left_r  <= left_nxt;
      armed_r <= armed_nxt;
      presc_r <= presc_nxt;
    end
  end

  always_comb begin
    res.event_res   = ev;
    res.coin_total  = sum_nxt;
    res.refund      = refund;
    res.temperature = temp_nxt;
    res.mode        = mode_code(mode_nxt);
    res.price_due   = price_nxt;
  end

endmodule

// File: rtl/cvc_outq.sv
module cvc_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cvc_pkg::res_t push_word,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output cvc_pkg::res_t head
);

  cvc_pkg::res_t ent_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr_r, rd_r;

  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_word;
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_r];

endmodule

// File: rtl/coffee_vending_controller.sv
// Coffee vending controller: takes one command word (size choice, coin, cancel,
// power off or one-second tick) per clock cycle while in_stall is low and returns
// exactly one result word for each, carrying the event, coin total, refund, boiler
// temperature, mode and price due. The state update for a word is done in the cycle
// it is accepted and the result is written into a two-word output buffer; in_stall
// rises only while both buffer entries are waiting to be taken. Configuration
// registers are written through cfg_we, cfg_idx and cfg_wdata; the user must do
// so only while the block is idle (not enforced); indexes above six are ignored.
module coffee_vending_controller #(
  parameter logic [6:0] START_TEMP = 7'd65
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_size_code,
  input  logic [7:0]  in_coin_cents,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_res,
  output logic [10:0] out_coin_total,
  output logic [10:0] out_refund,
  output logic [6:0]  out_temperature,
  output logic [1:0]  out_mode,
  output logic [9:0]  out_price_due
);

  cvc_pkg::cfg_t cfg;
  cvc_pkg::res_t res;
  cvc_pkg::res_t head;
  logic          push;
  logic          pop;
  logic          full;

  assign push     = in_valid && !full;
  assign pop      = out_valid && !out_stall;
  assign in_stall = full;

  cvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cvc_core #(
    .START_TEMP (START_TEMP)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (push),
    .cmd        (in_cmd),
    .size_code  (in_size_code),
    .coin_cents (in_coin_cents),
    .cfg        (cfg),
    .res        (res)
  );

  cvc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (res),
    .pop       (pop),
    .full      (full),
    .valid     (out_valid),
    .head      (head)
  );

  assign out_event_res   = head.event_res;
  assign out_coin_total  = head.coin_total;
  assign out_refund      = head.refund;
  assign out_temperature = head.temperature;
  assign out_mode        = head.mode;
  assign out_price_due   = head.price_due;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT = 400000;

  // codes the package leaves unnamed
  localparam logic [1:0] SIZE_UNKNOWN = 2'd3;
  localparam logic [2:0] CMD_UNUSED   = 3'd7;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam logic [7:0] GOOD_COINS [4] = '{cvc_pkg::COIN_10, cvc_pkg::COIN_20,
                                            cvc_pkg::COIN_50, cvc_pkg::COIN_100};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [1:0]  in_size_code = '0;
  logic [7:0]  in_coin_cents = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_event_res;
  logic [10:0] out_coin_total;
  logic [10:0] out_refund;
  logic [6:0]  out_temperature;
  logic [1:0]  out_mode;
  logic [9:0]  out_price_due;

  coffee_vending_controller dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_size_code   (in_size_code),
    .in_coin_cents  (in_coin_cents),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_coin_total (out_coin_total),
    .out_refund     (out_refund),
    .out_temperature(out_temperature),
    .out_mode       (out_mode),
    .out_price_due  (out_price_due)
  );

  always #4 clk = ~clk;

  // machine settings as last written
  logic [9:0] c_price_small, c_price_medium, c_price_big;
  logic [7:0] c_timeout, c_period;
  logic [6:0] c_hold, c_brew;

  // machine state as the words should leave it
  logic [1:0]  m_mode;
  logic [10:0] m_sum;
  logic [9:0]  m_price;
  logic [6:0]  m_temp;
  logic [7:0]  m_left;
  logic        m_armed;
  logic [7:0]  m_prescale;

  cvc_pkg::res_t predicted_words [$];

  bit gaps_on = 1'b1;
  int hold_off_len = 0;
  int words_sent = 0;
  int acted_words = 0;
  int dispensed_seen = 0;
  int refunds_seen = 0;
  int fails = 0;
  int cycle_count = 0;

  function automatic void return_to_idle();
    m_mode  = cvc_pkg::MODE_CODE_IDLE;
    m_sum   = '0;
    m_price = '0;
    m_armed = 1'b0;
    m_left  = '0;
  endfunction

  function automatic void reset_vend_model();
    c_price_small  = cvc_pkg::RST_PRICE_SMALL;
    c_price_medium = cvc_pkg::RST_PRICE_MEDIUM;
    c_price_big    = cvc_pkg::RST_PRICE_BIG;
    c_timeout      = cvc_pkg::RST_TIMEOUT;
    c_period       = cvc_pkg::RST_TEMP_PERIOD;
    c_hold         = cvc_pkg::RST_HOLD_TEMP;
    c_brew         = cvc_pkg::RST_BREW_TEMP;
    return_to_idle();
    m_temp     = 7'd65;
    m_prescale = '0;
  endfunction

  function automatic cvc_pkg::res_t vend_step(input logic [2:0] cmd, input logic [1:0] size,
                                              input logic [7:0] coin);
    cvc_pkg::res_t r;
    logic [9:0] p;
    logic paid;
    r = '0;
    r.event_res = cvc_pkg::EV_NONE;
    if (cmd == cvc_pkg::CMD_TICK) begin
      if (m_mode != cvc_pkg::MODE_CODE_OFF) begin
        if (m_armed) begin
          if (m_left != 0) m_left--;
          if (m_left == 0) begin
            r.refund = m_sum;
            r.event_res = cvc_pkg::EV_TIMEOUT;
            return_to_idle();
          end
        end
        m_prescale++;
        if (m_prescale >= c_period) begin
          m_prescale = '0;
          paid = (m_price != 0) && (m_price <= m_sum);
          // paid: heat up to brew point; otherwise hover around the hold point
          if (paid) begin
            if (m_temp <= c_brew && m_temp < cvc_pkg::TEMP_MAX) m_temp++;
          end else if (m_temp <= c_hold) begin
            if (m_temp < cvc_pkg::TEMP_MAX) m_temp++;
          end else if (m_temp > cvc_pkg::TEMP_MIN) begin
            m_temp--;
          end
        end
        if (m_mode == cvc_pkg::MODE_CODE_BREW && m_temp > c_brew) begin
          r.event_res = cvc_pkg::EV_DISPENSED;
          return_to_idle();
        end
      end
    end else if (cmd > cvc_pkg::CMD_TICK || m_mode == cvc_pkg::MODE_CODE_OFF ||
                 m_mode == cvc_pkg::MODE_CODE_BREW) begin
      r.event_res = cvc_pkg::EV_IGNORED;
    end else if (cmd == cvc_pkg::CMD_OFF) begin
      m_mode = cvc_pkg::MODE_CODE_OFF;
      r.event_res = cvc_pkg::EV_OFF;
    end else if (m_mode == cvc_pkg::MODE_CODE_IDLE) begin
      if (cmd == cvc_pkg::CMD_SIZE) begin
        case (size)
          cvc_pkg::SIZE_SMALL:  p = c_price_small;
          cvc_pkg::SIZE_MEDIUM: p = c_price_medium;
          cvc_pkg::SIZE_BIG:    p = c_price_big;
          default:              p = '0;
        endcase
        if (p != 0) begin
          m_price = p;
          m_mode = cvc_pkg::MODE_CODE_SIZE;
          r.event_res = cvc_pkg::EV_SIZE_OK;
        end else begin
          r.event_res = cvc_pkg::EV_BAD_SIZE;
        end
      end else begin
        r.event_res = cvc_pkg::EV_IGNORED;
      end
    end else if (cmd == cvc_pkg::CMD_CANCEL) begin
      r.refund = m_sum;
      r.event_res = cvc_pkg::EV_CANCEL;
      return_to_idle();
    end else if (cmd == cvc_pkg::CMD_SIZE) begin
      r.event_res = cvc_pkg::EV_IGNORED;
    end else if (coin == cvc_pkg::COIN_10 || coin == cvc_pkg::COIN_20 ||
                 coin == cvc_pkg::COIN_50 || coin == cvc_pkg::COIN_100) begin
      m_sum = m_sum + 11'(coin);
      m_armed = 1'b1;
      m_left = c_timeout;
      if (m_sum < m_price) begin
        r.event_res = cvc_pkg::EV_SHORT;
      end else begin
        m_armed = 1'b0;
        m_left = '0;
        m_mode = cvc_pkg::MODE_CODE_BREW;
        if (m_temp > c_brew) begin
          r.event_res = cvc_pkg::EV_DISPENSED;
          return_to_idle();
        end
      end
    end else begin
      r.event_res = cvc_pkg::EV_BAD_COIN;
    end
    r.coin_total  = m_sum;
    r.temperature = m_temp;
    r.mode        = m_mode;
    r.price_due   = m_price;
    return r;
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [1:0] size,
                           input logic [7:0] coin);
    int gap;
    cvc_pkg::res_t r;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_size_code  <= size;
    in_coin_cents <= coin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = vend_step(cmd, size, coin);
    predicted_words.push_back(r);
    words_sent++;
    if (r.event_res != cvc_pkg::EV_IGNORED) acted_words++;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cvc_pkg::REG_PRICE_SMALL:  c_price_small  = val;
      cvc_pkg::REG_PRICE_MEDIUM: c_price_medium = val;
      cvc_pkg::REG_PRICE_BIG:    c_price_big    = val;
      cvc_pkg::REG_TIMEOUT:      c_timeout      = val[7:0];
      cvc_pkg::REG_TEMP_PERIOD:  c_period       = val[7:0];
      cvc_pkg::REG_HOLD_TEMP:    c_hold         = val[6:0];
      cvc_pkg::REG_BREW_TEMP:    c_brew         = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ps, input int pm, input int pb, input int tmo,
                            input int per, input int hold, input int brew);
    settle();
    write_reg(cvc_pkg::REG_PRICE_SMALL, 10'(ps));
    write_reg(cvc_pkg::REG_PRICE_MEDIUM, 10'(pm));
    write_reg(cvc_pkg::REG_PRICE_BIG, 10'(pb));
    write_reg(cvc_pkg::REG_TIMEOUT, 10'(tmo));
    write_reg(cvc_pkg::REG_TEMP_PERIOD, 10'(per));
    write_reg(cvc_pkg::REG_HOLD_TEMP, 10'(hold));
    write_reg(cvc_pkg::REG_BREW_TEMP, 10'(brew));
  endtask

  // one customer: choose, pay (or not), then wait out the brew
  task automatic run_purchase();
    int steps;
    int pick;
    logic [1:0] sz;
    if ($urandom_range(0, 3) == 0) send_word(cvc_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
    if ($urandom_range(0, 7) == 0) send_word(cvc_pkg::CMD_CANCEL, 2'($urandom), 8'($urandom));
    sz = ($urandom_range(0, 7) == 0) ? SIZE_UNKNOWN : 2'($urandom_range(0, 2));
    send_word(cvc_pkg::CMD_SIZE, sz, 8'($urandom));
    steps = 0;
    while (m_mode == cvc_pkg::MODE_CODE_SIZE && steps < 30) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_word(cvc_pkg::CMD_COIN, 2'($urandom), GOOD_COINS[$urandom_range(0, 3)]);
      end else if (pick < 75) begin
        send_word(cvc_pkg::CMD_COIN, 2'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3))
          send_word(cvc_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        send_word(cvc_pkg::CMD_CANCEL, 2'($urandom), 8'($urandom));
      end else if (pick < 96) begin
        send_word(cvc_pkg::CMD_SIZE, 2'($urandom), 8'($urandom));
      end else begin
        send_word(3'($urandom_range(cvc_pkg::CMD_TICK + 1, CMD_UNUSED)), 2'($urandom),
                  8'($urandom));
      end
      steps++;
    end
    if (m_mode == cvc_pkg::MODE_CODE_SIZE) begin
      if (m_armed && $urandom_range(0, 1) == 1) begin
        while (m_mode == cvc_pkg::MODE_CODE_SIZE)
          send_word(cvc_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
      end else begin
        send_word(cvc_pkg::CMD_CANCEL, 2'($urandom), 8'($urandom));
      end
    end
    steps = 0;
    while (m_mode == cvc_pkg::MODE_CODE_BREW && steps < 600) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(3'($urandom_range(cvc_pkg::CMD_SIZE, cvc_pkg::CMD_CANCEL)), 2'($urandom),
                  8'($urandom));
      end else begin
        send_word(cvc_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
      end
      steps++;
    end
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = acted_words;
    while (acted_words - start < quota) run_purchase();
  endtask

  task automatic test_refusals();
    send_word(cvc_pkg::CMD_SIZE, SIZE_UNKNOWN, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, cvc_pkg::COIN_10);
    send_word(cvc_pkg::CMD_CANCEL, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(CMD_UNUSED, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_MEDIUM, 8'd0);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_BIG, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, 8'd255);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, cvc_pkg::COIN_50);
    send_word(cvc_pkg::CMD_CANCEL, cvc_pkg::SIZE_SMALL, 8'd0);
  endtask

  task automatic test_timeouts();
    settle();
    // a zero timeout behaves as one tick
    write_reg(cvc_pkg::REG_TIMEOUT, 10'd0);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, cvc_pkg::COIN_10);
    send_word(cvc_pkg::CMD_TICK, cvc_pkg::SIZE_SMALL, 8'd0);
  endtask

  task automatic test_brewing();
    settle();
    write_reg(cvc_pkg::REG_PRICE_SMALL, 10'd0);
    write_reg(cvc_pkg::REG_PRICE_BIG, 10'd30);
    write_reg(cvc_pkg::REG_BREW_TEMP, 10'd0);
    write_reg(cvc_pkg::REG_TEMP_PERIOD, 10'd0);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_SMALL, 8'd0);
    // overpaid and already hot: dispensed at once, change kept
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_BIG, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_BIG, cvc_pkg::COIN_50);
    settle();
    write_reg(cvc_pkg::REG_BREW_TEMP, 10'(m_temp + 2));
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_BIG, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_BIG, cvc_pkg::COIN_20);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_BIG, cvc_pkg::COIN_10);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_BIG, cvc_pkg::COIN_10);
    send_word(cvc_pkg::CMD_CANCEL, cvc_pkg::SIZE_BIG, 8'd0);
    while (m_mode == cvc_pkg::MODE_CODE_BREW)
      send_word(cvc_pkg::CMD_TICK, cvc_pkg::SIZE_BIG, 8'd0);
  endtask

  task automatic test_backpressure();
    settle();
    gaps_on = 1'b0;
    hold_off_len = 300;
    repeat (3) run_purchase();
    repeat (20) send_word(cvc_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
  endtask

  task automatic test_random();
    int h;
    gaps_on = 1'b1;
    h = $urandom_range(50, 80);
    set_config($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 300),
               $urandom_range(5, 40), $urandom_range(1, 4), h, h + $urandom_range(0, 5));
    run_phase(100);
    // hot end: temperature pinned at the top
    gaps_on = 1'b0;
    set_config(10, 20, 30, 1, 1, 127, 126);
    run_phase(100);
    gaps_on = 1'b1;
    set_config($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 300),
               $urandom_range(1, 10), 255, 60, 0);
    run_phase(100);
    // cold end, extreme prices and longest timeout
    set_config(1, 1023, 0, 255, 1, 0, $urandom_range(0, 3));
    run_phase(100);
    h = $urandom_range(30, 100);
    set_config($urandom_range(1, 100), $urandom_range(100, 1023), $urandom_range(1, 1023),
               $urandom_range(1, 60), $urandom_range(1, 3), h, h - 3 + $urandom_range(0, 6));
    write_reg(REG_UNUSED, 10'($urandom));
    run_phase(100);
  endtask

  task automatic test_brew_never_ready();
    settle();
    write_reg(cvc_pkg::REG_BREW_TEMP, 10'd127);
    write_reg(cvc_pkg::REG_TEMP_PERIOD, 10'd1);
    write_reg(cvc_pkg::REG_PRICE_SMALL, 10'd10);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_SMALL, cvc_pkg::COIN_10);
    repeat (10) send_word(cvc_pkg::CMD_TICK, cvc_pkg::SIZE_SMALL, 8'd0);
    // lower the brew point under the stuck machine to release it
    settle();
    write_reg(cvc_pkg::REG_BREW_TEMP, 10'd0);
    while (m_mode == cvc_pkg::MODE_CODE_BREW)
      send_word(cvc_pkg::CMD_TICK, cvc_pkg::SIZE_SMALL, 8'd0);
  endtask

  // last test: power off is only left by reset
  task automatic test_power_off();
    settle();
    gaps_on = 1'b1;
    write_reg(cvc_pkg::REG_PRICE_MEDIUM, 10'd500);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_MEDIUM, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_MEDIUM, cvc_pkg::COIN_20);
    send_word(cvc_pkg::CMD_OFF, cvc_pkg::SIZE_MEDIUM, 8'd0);
    send_word(cvc_pkg::CMD_COIN, cvc_pkg::SIZE_MEDIUM, cvc_pkg::COIN_100);
    send_word(cvc_pkg::CMD_SIZE, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_CANCEL, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(cvc_pkg::CMD_OFF, cvc_pkg::SIZE_SMALL, 8'd0);
    send_word(CMD_UNUSED, cvc_pkg::SIZE_SMALL, 8'd0);
    repeat (3) send_word(cvc_pkg::CMD_TICK, cvc_pkg::SIZE_SMALL, 8'd0);
  endtask

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // result side: compare each taken word with the oldest prediction
  initial begin
    cvc_pkg::res_t got;
    cvc_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.event_res   = out_event_res;
        got.coin_total  = out_coin_total;
        got.refund      = out_refund;
        got.temperature = out_temperature;
        got.mode        = out_mode;
        got.price_due   = out_price_due;
        #1;
        if (predicted_words.size() == 0) begin
          $error("result word with nothing expected: event_res %0d", got.event_res);
          fails++;
        end else begin
          want = predicted_words.pop_front();
          if (want.event_res == cvc_pkg::EV_DISPENSED) dispensed_seen++;
          if (want.event_res == cvc_pkg::EV_CANCEL || want.event_res == cvc_pkg::EV_TIMEOUT)
            refunds_seen++;
          check_field("event_res", want.event_res, got.event_res);
          check_field("coin_total", want.coin_total, got.coin_total);
          check_field("refund", want.refund, got.refund);
          check_field("temperature", want.temperature, got.temperature);
          check_field("mode", want.mode, got.mode);
          check_field("price_due", want.price_due, got.price_due);
        end
      end
    end
  end

  // receiver stalls: random per word, plus one long hold-off on request
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      n = gaps_on ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_vend_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_refusals();
    test_timeouts();
    test_brewing();
    test_backpressure();
    test_random();
    test_brew_never_ready();
    test_power_off();
    settle();
    $display("covered %0d command words (%0d acted on): %0d cups dispensed, %0d refunds",
             words_sent, acted_words, dispensed_seen, refunds_seen);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
